FILE: rtl/keyed_slot_table_unit_macros.svh
`ifndef KEYED_SLOT_TABLE_UNIT_MACROS_SVH
`define KEYED_SLOT_TABLE_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define KST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define KST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/kst_pkg.sv
`timescale 1ns / 1ps

package kst_pkg;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_ALLOC  = 2'd1,
		REQ_FREE   = 2'd2,
		REQ_FILL   = 2'd3
	} req_e;

	typedef struct packed {
		req_e               req_type;
		logic signed [15:0] handle;
		logic [63:0]        owner_id;
		logic [6:0]         slot;
		logic [63:0]        worker_id;
	} req_word_t;

	typedef struct packed {
		logic        found;
		logic [6:0]  slot_index;
		logic [63:0] worker_out;
	} rsp_word_t;

	typedef struct packed {
		logic [15:0] handle;
		logic [63:0] owner;
		logic [63:0] worker;
	} slot_entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FINISH
	} state_e;

	typedef struct packed {
		logic clear;
		logic start;
		logic scan;
		logic write;
		logic load;
	} kst_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic scan_done;
		logic scan_hit;
		logic req_free;
	} kst_sts_t;

	localparam logic [63:0] INVALID_ID = '1;

endpackage

FILE: rtl/kst_datapath.sv
`timescale 1ns / 1ps

module kst_datapath
	import kst_pkg::*;
#(
	parameter int SLOTS = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_word_t req,
	input  kst_cmd_t  cmd,
	output kst_sts_t  sts,
	output rsp_word_t rsp
);

	localparam int AW = $clog2(SLOTS);

	slot_entry_t mem [SLOTS];

	req_word_t   req_q;
	logic [AW:0] idx_q;
	logic [AW-1:0] hit_addr_q;
	rsp_word_t   res_q;
	rsp_word_t   rsp_q;

	slot_entry_t rdata_s1;
	logic        rvld_s1;
	logic [AW-1:0] ridx_s1;

	logic          rd_en;
	logic          we;
	logic [AW-1:0] wa;
	slot_entry_t   wd;
	logic          match;
	logic          hit_now;
	logic          last_s1;
	logic          slot_ok;
	logic [31:0]   ridx_w;
	logic [31:0]   slot_w;
	slot_entry_t   fill_entry;
	slot_entry_t   free_entry;

	assign ridx_w  = 32'(ridx_s1);
	assign slot_w  = 32'(req_q.slot);
	assign slot_ok = slot_w < 32'(SLOTS);

	assign rd_en = cmd.scan && (idx_q < (AW+1)'(SLOTS));

	assign free_entry = '{handle: '1, owner: INVALID_ID, worker: INVALID_ID};
	assign fill_entry = '{handle: req_q.handle, owner: req_q.owner_id,
	                      worker: req_q.worker_id};

	always_comb begin
		case (req_q.req_type)
			REQ_ALLOC: match = rdata_s1.handle[15];
			REQ_LOOKUP, REQ_FREE: match = (rdata_s1.handle == req_q.handle)
			                           && (rdata_s1.owner == req_q.owner_id);
			default: match = 1'b0;
		endcase
	end

	assign hit_now = rvld_s1 && match;
	assign last_s1 = rvld_s1 && (ridx_s1 == AW'(SLOTS - 1));

	assign sts.clear_last = (idx_q == (AW+1)'(SLOTS - 1));
	assign sts.scan_done  = hit_now || last_s1;
	assign sts.scan_hit   = hit_now;
	assign sts.req_free   = (req_q.req_type == REQ_FREE);

	always_comb begin
		we = 1'b0;
		wa = idx_q[AW-1:0];
		wd = free_entry;
		if (cmd.clear) begin
			we = 1'b1;
		end else if (cmd.write) begin
			if (req_q.req_type == REQ_FILL) begin
				we = slot_ok;
				wa = slot_w[AW-1:0];
				wd = fill_entry;
			end else begin
				we = 1'b1;
				wa = hit_addr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			rvld_s1 <= 1'b0;
			ridx_s1 <= '0;
		end else begin
			rvld_s1 <= rd_en;
			if (rd_en) begin
				ridx_s1 <= idx_q[AW-1:0];
			end
			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.clear || rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req;
		end
		if (cmd.scan && sts.scan_done) begin
			hit_addr_q       <= ridx_s1;
			res_q.found      <= hit_now;
			res_q.slot_index <= hit_now ? ridx_w[6:0] : 7'd0;
			res_q.worker_out <= (hit_now && req_q.req_type == REQ_LOOKUP)
			                    ? rdata_s1.worker : INVALID_ID;
		end else if (cmd.write && req_q.req_type == REQ_FILL) begin
			res_q.found      <= slot_ok;
			res_q.slot_index <= slot_ok ? req_q.slot : 7'd0;
			res_q.worker_out <= INVALID_ID;
		end
		if (cmd.load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: rtl/kst_ctrl.sv
`timescale 1ns / 1ps
`include "keyed_slot_table_unit_macros.svh"

module kst_ctrl
	import kst_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  req_e     req_type,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  kst_sts_t sts,
	output kst_cmd_t cmd
);

	state_e state_q;
	state_e state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !rsp_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_nxt = (req_type == REQ_FILL) ? ST_WRITE : ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = (sts.req_free && sts.scan_hit) ? ST_WRITE : ST_FINISH;
				end
			end
			ST_WRITE: state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (slot_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.start = req_valid;
			end
			ST_SCAN:   cmd.scan = 1'b1;
			ST_WRITE:  cmd.write = 1'b1;
			ST_FINISH: cmd.load = slot_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	`KST_ASSERT_NOW(a_no_accept_in_clear, clk, arst_n, state_q == ST_CLEAR, req_stall, "request taken during clear pass")
	`KST_ASSERT_NEXT(a_free_hit_writes, clk, arst_n, state_q == ST_SCAN && sts.scan_done && sts.scan_hit && sts.req_free, state_q == ST_WRITE, "free hit did not clear slot")
	`KST_ASSERT_NEXT(a_finish_delivers, clk, arst_n, state_q == ST_FINISH && slot_free, out_valid_q && state_q == ST_IDLE, "result not loaded")
	`KST_ASSERT_NEXT(a_stalled_rsp_held, clk, arst_n, out_valid_q && rsp_stall, out_valid_q, "stalled result dropped")

endmodule

FILE: rtl/keyed_slot_table_unit.sv
`timescale 1ns / 1ps
// Operation: lookup, allocate and free scan one slot a cycle from index 0 and stop at the
// first hit or after the last slot; a free hit then passes through a write state that clears
// the slot, and a fill writes its slot directly with no scan.
// Flow: one word in flight; the next is taken in the cycle after the result loads, and a
// result waits in the finish state while an earlier result is still held by rsp_stall.
// Reset: control clears at once; a clearing pass then frees every slot, holding off input.
module keyed_slot_table_unit
	import kst_pkg::*;
#(
	parameter int SLOTS = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	kst_cmd_t cmd;
	kst_sts_t sts;

	kst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	kst_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

FILE: verif/keyed_slot_table_unit_tb.sv
`timescale 1ns / 1ps

module keyed_slot_table_unit_tb
	import kst_pkg::*;
();

	localparam int SLOT_COUNT = 128;
	localparam int QUIET_LIMIT = 4000;
	localparam logic signed [15:0] FREE_HANDLE = -16'sd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_word_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_word_t rsp;

	logic [15:0] tbl_handle [SLOT_COUNT];
	logic [63:0] tbl_owner [SLOT_COUNT];
	logic [63:0] tbl_worker [SLOT_COUNT];
	rsp_word_t expected_rsp [$];
	logic signed [15:0] key_handles [6];
	logic [63:0] key_owners [4];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int err_count = 0;
	int quiet_cycles = 0;

	keyed_slot_table_unit #(.SLOTS(SLOT_COUNT)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic void note_error(string msg);
		err_count++;
		if (err_count <= 10) $display("%s", msg);
	endfunction

	function automatic rsp_word_t apply_request(req_word_t w);
		rsp_word_t r;
		int hit_at;
		int i;
		r.found = 1'b0;
		r.slot_index = '0;
		r.worker_out = INVALID_ID;
		hit_at = -1;
		case (w.req_type)
			REQ_LOOKUP, REQ_FREE: begin
				for (i = 0; i < SLOT_COUNT; i++)
					if (hit_at < 0 && tbl_handle[i] == w.handle && tbl_owner[i] == w.owner_id)
						hit_at = i;
				if (hit_at >= 0) begin
					r.found = 1'b1;
					r.slot_index = 7'(hit_at);
					if (w.req_type == REQ_LOOKUP) begin
						r.worker_out = tbl_worker[hit_at];
					end else begin
						tbl_handle[hit_at] = FREE_HANDLE;
						tbl_owner[hit_at] = INVALID_ID;
						tbl_worker[hit_at] = INVALID_ID;
					end
				end
			end
			REQ_ALLOC: begin
				for (i = 0; i < SLOT_COUNT; i++)
					if (hit_at < 0 && tbl_handle[i][15]) hit_at = i;
				if (hit_at >= 0) begin
					r.found = 1'b1;
					r.slot_index = 7'(hit_at);
				end
			end
			default: begin
				if (int'(w.slot) < SLOT_COUNT) begin
					tbl_handle[w.slot] = w.handle;
					tbl_owner[w.slot] = w.owner_id;
					tbl_worker[w.slot] = w.worker_id;
					r.found = 1'b1;
					r.slot_index = w.slot;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : check_rsp
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				note_error($sformatf("unexpected word: found=%0d slot=%0d worker=%h",
					rsp.found, rsp.slot_index, rsp.worker_out));
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.found !== want.found || rsp.slot_index !== want.slot_index ||
						rsp.worker_out !== want.worker_out)
					note_error($sformatf(
						"mismatch: expected found=%0d slot=%0d worker=%h, got found=%0d slot=%0d worker=%h",
						want.found, want.slot_index, want.worker_out,
						rsp.found, rsp.slot_index, rsp.worker_out));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_word(input req_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_rsp.push_back(apply_request(w));
		@(negedge clk);
	endtask

	task automatic send_req(input req_e kind, input logic signed [15:0] h,
			input logic [63:0] own, input logic [6:0] s, input logic [63:0] wk);
		req_word_t w;
		w.req_type = kind;
		w.handle = h;
		w.owner_id = own;
		w.slot = s;
		w.worker_id = wk;
		send_word(w);
	endtask

	task automatic wait_results_done();
		req_valid <= 1'b0;
		do @(negedge clk); while (expected_rsp.size() != 0);
	endtask

	task automatic test_reset_contents();
		send_req(REQ_LOOKUP, FREE_HANDLE, INVALID_ID, 7'($urandom), rand64());
		send_req(REQ_ALLOC, 16'sd0, rand64(), 7'($urandom), rand64());
		send_req(REQ_LOOKUP, 16'sd0, 64'd0, 7'($urandom), rand64());
		send_req(REQ_FREE, 16'sd5, rand64(), 7'($urandom), rand64());
	endtask

	task automatic test_each_request();
		send_req(REQ_FILL, 16'sd32767, INVALID_ID, 7'd0, 64'd0);
		send_req(REQ_FILL, 16'sd0, 64'd0, 7'd127, INVALID_ID);
		send_req(REQ_LOOKUP, 16'sd32767, INVALID_ID, 7'($urandom), rand64());
		send_req(REQ_LOOKUP, 16'sd0, 64'd0, 7'($urandom), rand64());
		send_req(REQ_FILL, 16'sd0, 64'd0, 7'd5, rand64());
		send_req(REQ_LOOKUP, 16'sd0, 64'd0, 7'($urandom), rand64());
		send_req(REQ_FREE, 16'sd0, 64'd0, 7'($urandom), rand64());
		send_req(REQ_LOOKUP, 16'sd0, 64'd0, 7'($urandom), rand64());
		send_req(REQ_ALLOC, 16'sd0, rand64(), 7'($urandom), rand64());
		send_req(REQ_FILL, FREE_HANDLE, key_owners[2], 7'd1, rand64());
		send_req(REQ_ALLOC, 16'sd0, rand64(), 7'($urandom), rand64());
		send_req(REQ_LOOKUP, FREE_HANDLE, key_owners[2], 7'($urandom), rand64());
		send_req(REQ_FREE, 16'sd0, 64'd0, 7'($urandom), rand64());
		send_req(REQ_LOOKUP, 16'sd0, 64'd0, 7'($urandom), rand64());
		wait_results_done();
	endtask

	task automatic test_key_of_free_slot();
		send_req(REQ_FREE, FREE_HANDLE, INVALID_ID, 7'($urandom), rand64());
		send_req(REQ_LOOKUP, FREE_HANDLE, INVALID_ID, 7'($urandom), rand64());
		send_req(REQ_ALLOC, FREE_HANDLE, INVALID_ID, 7'($urandom), rand64());
	endtask

	task automatic test_full_table();
		int i;
		logic signed [15:0] h;
		logic [63:0] own;
		for (i = 0; i < SLOT_COUNT; i++)
			send_req(REQ_FILL, key_handles[$urandom_range(4)], key_owners[$urandom_range(3)],
				7'(i), rand64());
		send_req(REQ_ALLOC, FREE_HANDLE, INVALID_ID, 7'($urandom), rand64());
		send_req(REQ_LOOKUP, FREE_HANDLE, INVALID_ID, 7'($urandom), rand64());
		h = key_handles[$urandom_range(4)];
		own = key_owners[$urandom_range(3)];
		send_req(REQ_FREE, h, own, 7'($urandom), rand64());
		send_req(REQ_ALLOC, h, own, 7'($urandom), rand64());
		send_req(REQ_LOOKUP, h, own, 7'($urandom), rand64());
	endtask

	task automatic test_random_traffic(input int n);
		int sent;
		int pick;
		int i;
		logic signed [15:0] h;
		logic [63:0] own;
		logic [6:0] s;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			h = key_handles[$urandom_range(5)];
			own = key_owners[$urandom_range(3)];
			if ($urandom_range(9) == 0) begin
				h = 16'($urandom_range(32767));
				own = rand64();
			end
			if ($urandom_range(1) == 0)
				s = 7'($urandom_range(15));
			else
				s = 7'($urandom);
			if (pick < 20) begin
				for (i = SLOT_COUNT - 1; i >= 0; i--)
					if (tbl_handle[i][15])
						s = i[6:0];
				send_req(REQ_ALLOC, h, own, 7'($urandom), rand64());
				send_req(REQ_FILL, h, own, s, rand64());
				send_req(REQ_LOOKUP, h, own, 7'($urandom), rand64());
				sent += 3;
			end else begin
				if (pick < 50)
					send_req(REQ_LOOKUP, h, own, 7'($urandom), rand64());
				else if (pick < 65)
					send_req(REQ_FREE, h, own, 7'($urandom), rand64());
				else if (pick < 90)
					send_req(REQ_FILL, h, own, s, rand64());
				else
					send_req(REQ_ALLOC, h, own, 7'($urandom), rand64());
				sent++;
			end
		end
	endtask

	initial begin
		int i;
		key_handles = '{16'sd0, 16'sd1, 16'sd7, 16'sd4660, 16'sd32767, -16'sd1};
		key_owners = '{64'd0, INVALID_ID, rand64(), rand64()};
		for (i = 0; i < SLOT_COUNT; i++) begin
			tbl_handle[i] = FREE_HANDLE;
			tbl_owner[i] = INVALID_ID;
			tbl_worker[i] = INVALID_ID;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_each_request();
		test_key_of_free_slot();
		test_full_table();
		test_random_traffic(360);
		wait_results_done();

		send_idle_pct = 52;
		test_random_traffic(360);
		wait_results_done();

		send_idle_pct = 0;
		stall_pct = 52;
		test_random_traffic(360);
		wait_results_done();

		send_idle_pct = 23;
		stall_pct = 23;
		test_random_traffic(360);
		wait_results_done();

		repeat (SLOT_COUNT + 8) @(negedge clk);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/kst_pkg.sv
rtl/kst_datapath.sv
rtl/kst_ctrl.sv
rtl/keyed_slot_table_unit.sv
verif/keyed_slot_table_unit_tb.sv
